### hw/rtl/fqrs_pkg.sv
// ============================================================================
// fqrs_pkg: shared types and constants of the FASTQ record splitter
// Holds the field widths, the newline code, the line codes and the result
// status codes.
// ============================================================================
package fqrs_pkg;

    // Field widths.
    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int COUNT_BITS  = 32;

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [LENGTH_BITS-1:0] length_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [1:0]             status_t;
    typedef logic [1:0]             line_t;

    // Saturation limit of the length counters.
    localparam length_t LEN_MAX = {LENGTH_BITS{1'b1}};

    // Newline byte that closes a line.
    localparam logic [7:0] NL_BYTE = 8'd10;

    // Line of a four-line record.
    localparam line_t LINE_HEADER = 2'd0;
    localparam line_t LINE_BASES  = 2'd1;
    localparam line_t LINE_SEP    = 2'd2;
    localparam line_t LINE_QUALS  = 2'd3;

    // Result status codes.
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_EXHAUSTED = 2'd1;
    localparam status_t ST_TRUNCATED = 2'd2;

endpackage

### hw/rtl/fastq_record_splitter.sv
// ============================================================================
// fastq_record_splitter: FASTQ four-line record parser
// Takes chunk text one byte per transfer and emits one descriptor per record
// with the header, bases and quality offsets, header length and sequence
// length, or a status for exhausted or truncated records.
// ============================================================================
//
//  Channel | Signals                                        | Moves
//  --------+------------------------------------------------+-----------------
//  in      | in_valid, in_ready, data_byte, chunk_end,      | one text byte
//          | restart                                        |
//  out     | out_valid, out_ready, status, record_index,    | one record
//          | meta_offset, header_len, bases_offset, seq_len,| descriptor
//          | quals_offset                                   |
//  cfg     | cfg_valid, cfg_ready, cfg_data                 | record limit
//
//  One byte per cycle while the output is not stalled: a byte sits in the
//  input register, is parsed by the counter and compare logic and its result
//  lands in the output register, from which it is offered.
//  Reset clears the parse state and the record limit; no clearing pass is
//  needed. A held result stalls the parse stage only while out_ready is low,
//  and the input register then fills and drops in_ready. cfg_ready is always
//  high.
//
module fastq_record_splitter
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   chunk_end,
    input  logic                   restart,

    output logic                   out_valid,
    input  logic                   out_ready,
    output fqrs_pkg::status_t      status,
    output fqrs_pkg::count_t       record_index,
    output fqrs_pkg::offset_t      meta_offset,
    output fqrs_pkg::length_t      header_len,
    output fqrs_pkg::offset_t      bases_offset,
    output fqrs_pkg::length_t      seq_len,
    output fqrs_pkg::offset_t      quals_offset,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  fqrs_pkg::count_t       cfg_data
);

    import fqrs_pkg::*;

    // Input register.
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       s1_restart_reg;

    // Parse state.
    offset_t byte_offset_reg;
    line_t   line_reg;
    length_t len_reg;
    logic    skip_reg;
    count_t  count_reg;
    offset_t held_meta_offset_reg;
    length_t held_header_len_reg;
    offset_t held_bases_offset_reg;
    offset_t held_quals_offset_reg;
    count_t  record_limit_reg;

    // Output register.
    logic    out_valid_reg;
    status_t status_reg;
    count_t  index_reg;
    offset_t meta_offset_reg;
    length_t header_len_reg;
    offset_t bases_offset_reg;
    length_t seq_len_reg;
    offset_t quals_offset_reg;

    // Parse step signals.
    logic    advance;
    offset_t cur_off;
    offset_t next_off;
    line_t   cur_line;
    length_t cur_len;
    logic    cur_skip;
    count_t  cur_count;
    length_t len_work;
    logic    closes;
    logic    is_nl;

    line_t   line_next;
    length_t len_next;
    logic    skip_next;
    count_t  count_next;
    logic    result_next;
    status_t status_next;
    logic    full_record;

    // Handshakes.
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg    <= data_byte;
            s1_last_reg    <= chunk_end;
            s1_restart_reg <= restart;
        end
    end

    // State seen by this byte, after an optional restart.
    always_comb
    begin
        cur_off   = s1_restart_reg ? '0 : byte_offset_reg;
        cur_line  = s1_restart_reg ? LINE_HEADER : line_reg;
        cur_len   = s1_restart_reg ? '0 : len_reg;
        cur_skip  = s1_restart_reg ? 1'b1 : skip_reg;
        cur_count = s1_restart_reg ? '0 : count_reg;
        next_off  = cur_off + offset_t'(1);
        is_nl     = (s1_byte_reg == NL_BYTE);
    end

    // Line length and line close detection.
    always_comb
    begin
        if (cur_skip)
        begin
            len_work = '0;
            closes   = s1_last_reg;
        end
        else
        begin
            len_work = (is_nl || cur_len == LEN_MAX) ? cur_len : cur_len + length_t'(1);
            closes   = is_nl || s1_last_reg;
        end
    end

    // Record sequencing and result selection.
    always_comb
    begin
        line_next   = cur_line;
        len_next    = len_work;
        skip_next   = 1'b0;
        count_next  = cur_count;
        result_next = 1'b0;
        status_next = ST_OK;
        full_record = 1'b0;

        if (closes)
        begin
            len_next = '0;
            unique case (cur_line)
                LINE_HEADER: line_next = LINE_BASES;
                LINE_BASES:  line_next = LINE_SEP;
                LINE_SEP:    line_next = LINE_QUALS;
                LINE_QUALS:
                begin
                    line_next   = LINE_HEADER;
                    skip_next   = 1'b1;
                    result_next = 1'b1;
                    if (cur_count == record_limit_reg)
                    begin
                        status_next = ST_EXHAUSTED;
                    end
                    else
                    begin
                        full_record = 1'b1;
                        count_next  = cur_count + count_t'(1);
                    end
                end
                default: line_next = LINE_HEADER;
            endcase

            if (s1_last_reg && cur_line != LINE_QUALS)
            begin
                result_next = 1'b1;
                status_next = ST_TRUNCATED;
            end
        end

        // Chunk end always returns to the start of a header line.
        if (s1_last_reg)
        begin
            line_next = LINE_HEADER;
            len_next  = '0;
            skip_next = 1'b1;
        end
    end

    // Parse state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg  <= '0;
            line_reg         <= LINE_HEADER;
            len_reg          <= '0;
            skip_reg         <= 1'b1;
            count_reg        <= '0;
            record_limit_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                record_limit_reg <= cfg_data;
            end
            if (advance)
            begin
                byte_offset_reg <= next_off;
                line_reg        <= line_next;
                len_reg         <= len_next;
                skip_reg        <= skip_next;
                count_reg       <= count_next;
                out_valid_reg   <= result_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Held record fields. Each is written before any record can use it.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (cur_skip)
            begin
                held_meta_offset_reg <= next_off;
            end
            if (closes && cur_line == LINE_HEADER)
            begin
                held_header_len_reg   <= len_work;
                held_bases_offset_reg <= next_off;
            end
            if (closes && cur_line == LINE_SEP)
            begin
                held_quals_offset_reg <= next_off;
            end
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (advance && result_next)
        begin
            status_reg       <= status_next;
            index_reg        <= cur_count;
            meta_offset_reg  <= full_record ? held_meta_offset_reg : '0;
            header_len_reg   <= full_record ? held_header_len_reg : '0;
            bases_offset_reg <= full_record ? held_bases_offset_reg : '0;
            seq_len_reg      <= full_record ? len_work : '0;
            quals_offset_reg <= full_record ? held_quals_offset_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign record_index = index_reg;
    assign meta_offset  = meta_offset_reg;
    assign header_len   = header_len_reg;
    assign bases_offset = bases_offset_reg;
    assign seq_len      = seq_len_reg;
    assign quals_offset = quals_offset_reg;

`ifndef SYNTHESIS
    // A byte that ends the chunk leaves the parser at a fresh header line.
    a_chunk_end_rewinds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && s1_last_reg) |=> (skip_reg && line_reg == LINE_HEADER && len_reg == '0))
        else $error("chunk end did not rewind the line state");

    // The record count holds, steps by one, or restarts from zero.
    a_count_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> (count_reg == $past(count_reg) ||
                     count_reg == $past(count_reg) + count_t'(1) ||
                     count_reg == '0))
        else $error("record count jumped");

    // Non-ok results carry zero offsets and lengths.
    a_status_zero_fields: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |->
            (meta_offset == '0 && header_len == '0 && bases_offset == '0 &&
             seq_len == '0 && quals_offset == '0))
        else $error("non-ok result carries record fields");

    // The parse state does not move while the byte is stalled.
    a_hold_when_stalled: assert property (
        @(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(byte_offset_reg) && $stable(line_reg) && $stable(count_reg))
        else $error("parse state moved without a byte");
`endif

endmodule
